/* rtl/core/usbcf_pkg.sv */
`timescale 1ns / 1ps

package usbcf_pkg;

  localparam logic [7:0] TYPE_CONFIG    = 8'h02;
  localparam logic [7:0] TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
  localparam logic [7:0] XFER_MASK      = 8'h03;
  localparam logic [7:0] XFER_BULK      = 8'h02;
  localparam logic [7:0] DIR_IN         = 8'h80;
  localparam logic [15:0] DEFAULT_PACKET = 16'd64;
  localparam logic [7:0] MIN_LONG_DESC  = 8'd9;
  localparam logic [7:0] MIN_EP_DESC    = 8'd7;
  localparam logic [7:0] MIN_DESC       = 8'd2;
  localparam logic [7:0] DEFAULT_CONFIG = 8'd1;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  config_value;
    logic [7:0]  in_endpoint;
    logic [15:0] in_max_packet;
    logic [7:0]  out_endpoint;
    logic [15:0] out_max_packet;
  } result_t;

endpackage

/* rtl/core/usbcf_in_stage.sv */
`timescale 1ns / 1ps

module usbcf_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,
  input  logic                  s_axis_tlast,
  input  logic                  advance,
  output logic                  item_valid,
  output usbcf_pkg::byte_item_t item
);
  import usbcf_pkg::*;

  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.desc_byte <= s_axis_tdata;
      item.last_byte <= s_axis_tlast;
    end
  end

endmodule

/* rtl/core/usbcf_parser.sv */
`timescale 1ns / 1ps

module usbcf_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  usbcf_pkg::byte_item_t item,
  output logic                  result_load,
  output usbcf_pkg::result_t    result
);
  import usbcf_pkg::*;

  logic [7:0]       pos_in_desc, pos_in_desc_next;
  logic [7:0]       desc_length, desc_length_next;
  logic [7:0]       desc_kind, desc_kind_next;
  logic [3:0][7:0]  held_bytes, held_bytes_next;
  logic             parse_stopped, parse_stopped_next;
  logic [7:0]       current_alt, current_alt_next;
  logic [7:0]       best_in_addr, best_in_addr_next;
  logic [15:0]      best_in_size, best_in_size_next;
  logic [7:0]       best_out_addr, best_out_addr_next;
  logic [15:0]      best_out_size, best_out_size_next;
  logic [7:0]       chosen_config, chosen_config_next;

  logic [7:0]  b;
  logic [1:0]  held_idx;
  logic        commit;
  logic [15:0] ep_size;

  assign b        = item.desc_byte;
  assign held_idx = 2'(pos_in_desc[1:0] - 2'd2);

  always_comb begin
    pos_in_desc_next   = pos_in_desc;
    desc_length_next   = desc_length;
    desc_kind_next     = desc_kind;
    held_bytes_next    = held_bytes;
    parse_stopped_next = parse_stopped;
    current_alt_next   = current_alt;
    best_in_addr_next  = best_in_addr;
    best_in_size_next  = best_in_size;
    best_out_addr_next = best_out_addr;
    best_out_size_next = best_out_size;
    chosen_config_next = chosen_config;
    commit             = 1'b0;
    ep_size            = '0;

    if (!parse_stopped) begin
      if (pos_in_desc == 8'd0 && b < MIN_DESC) begin
        parse_stopped_next = 1'b1;
      end else begin
        if (pos_in_desc == 8'd0) begin
          desc_length_next = b;
        end else if (pos_in_desc == 8'd1) begin
          desc_kind_next = b;
        end else if (pos_in_desc <= 8'd5) begin
          held_bytes_next[held_idx] = b;
        end
        commit = ({1'b0, pos_in_desc} + 9'd1) == {1'b0, desc_length_next};
        pos_in_desc_next = commit ? 8'd0 : 8'(pos_in_desc + 8'd1);
      end
    end

    // sub-descriptor complete: apply its effect
    ep_size = {held_bytes_next[3], held_bytes_next[2]};
    if (ep_size == 16'd0) begin
      ep_size = DEFAULT_PACKET;
    end
    if (commit) begin
      if (desc_kind_next == TYPE_CONFIG && desc_length_next >= MIN_LONG_DESC) begin
        chosen_config_next = (held_bytes_next[3] != 8'd0) ? held_bytes_next[3]
                                                           : DEFAULT_CONFIG;
      end else if (desc_kind_next == TYPE_INTERFACE
                   && desc_length_next >= MIN_LONG_DESC) begin
        current_alt_next = held_bytes_next[1];
      end else if (desc_kind_next == TYPE_ENDPOINT && desc_length_next >= MIN_EP_DESC
                   && current_alt == 8'd0) begin
        if ((held_bytes_next[1] & XFER_MASK) == XFER_BULK) begin
          if ((held_bytes_next[0] & DIR_IN) != 8'd0) begin
            best_in_addr_next = held_bytes_next[0];
            best_in_size_next = ep_size;
          end else begin
            best_out_addr_next = held_bytes_next[0];
            best_out_size_next = ep_size;
          end
        end
      end
    end

    result.found        = best_in_addr_next != 8'd0 && best_out_addr_next != 8'd0;
    result.config_value = chosen_config_next;
    result.in_endpoint    = result.found ? best_in_addr_next  : 8'd0;
    result.in_max_packet  = result.found ? best_in_size_next  : 16'd0;
    result.out_endpoint   = result.found ? best_out_addr_next : 8'd0;
    result.out_max_packet = result.found ? best_out_size_next : 16'd0;
  end

  assign result_load = advance && item.last_byte;

  always_ff @(posedge clk) begin
    if (rst || result_load) begin
      pos_in_desc   <= '0;
      desc_length   <= '0;
      desc_kind     <= '0;
      held_bytes    <= '0;
      parse_stopped <= 1'b0;
      current_alt   <= '0;
      best_in_addr  <= '0;
      best_in_size  <= '0;
      best_out_addr <= '0;
      best_out_size <= '0;
      chosen_config <= DEFAULT_CONFIG;
    end else if (advance) begin
      pos_in_desc   <= pos_in_desc_next;
      desc_length   <= desc_length_next;
      desc_kind     <= desc_kind_next;
      held_bytes    <= held_bytes_next;
      parse_stopped <= parse_stopped_next;
      current_alt   <= current_alt_next;
      best_in_addr  <= best_in_addr_next;
      best_in_size  <= best_in_size_next;
      best_out_addr <= best_out_addr_next;
      best_out_size <= best_out_size_next;
      chosen_config <= chosen_config_next;
    end
  end

  a_pos_within_length: assert property (@(posedge clk) disable iff (rst)
    pos_in_desc != 8'd0 |-> pos_in_desc < desc_length)
    else $error("position past sub-descriptor length");

  a_stopped_at_start: assert property (@(posedge clk) disable iff (rst)
    parse_stopped |-> pos_in_desc == 8'd0)
    else $error("parse stopped mid sub-descriptor");

  a_config_nonzero: assert property (@(posedge clk) disable iff (rst)
    chosen_config != 8'd0)
    else $error("configuration value zero");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    result_load |=> pos_in_desc == 8'd0 && !parse_stopped && best_in_addr == 8'd0
                    && best_out_addr == 8'd0)
    else $error("state not cleared after result");

endmodule

/* rtl/core/usbcf_out_stage.sv */
`timescale 1ns / 1ps

module usbcf_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               result_load,
  input  usbcf_pkg::result_t result,
  output logic               out_free,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [55:0]        m_axis_tdata,
  output logic               m_axis_tuser
);
  import usbcf_pkg::*;

  result_t held;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= result_load;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load && out_free) begin
      held <= result;
    end
  end

  assign m_axis_tdata = {held.out_max_packet, held.out_endpoint, held.in_max_packet,
                         held.in_endpoint, held.config_value};
  assign m_axis_tuser = held.found;

endmodule

/* rtl/core/usb_config_desc_bulk_endpoint_finder_top.sv */
`timescale 1ns / 1ps

// scans a usb configuration descriptor for a bulk in / bulk out endpoint pair
// input stream: one descriptor byte per item on s_axis, tlast on the final byte
// output stream: one item per descriptor, sent for the item carrying tlast
// the byte is registered on accept and parsed from that register straight into
// the output register, so a result passes the input register and then the output
// register, where it becomes visible
// throughput is one byte per cycle while no final byte waits for the output register;
// the per-byte parse is field latching plus the commit compare, no loop
// reset clears all parse state; the configuration value defaults to 1
// a stalled m_axis only holds back a final byte: ordinary bytes keep flowing
// while a finished result waits, and s_axis_tready drops only when another
// final byte needs the occupied output register
module usb_config_desc_bulk_endpoint_finder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // desc_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // config_value, in_endpoint, in_max_packet, out_endpoint, out_max_packet
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser    // found
);
  import usbcf_pkg::*;

  logic       item_valid;
  byte_item_t item;
  logic       advance;
  logic       out_free;
  logic       result_load;
  result_t    result;

  assign advance = item_valid && (!item.last_byte || out_free);

  usbcf_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  usbcf_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (item),
    .result_load (result_load),
    .result      (result)
  );

  usbcf_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .result_load   (result_load),
    .result        (result),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
